[src/ic_pkg.sv]
// Shared constants and the token type that travels along the comparator chain.
`default_nettype none
package ic_pkg;

    localparam int MAX_ITEMS = 256;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 15;
    localparam int COUNT_MAX = 32767;
    localparam int IDX_W     = $clog2(MAX_ITEMS + 1);
    localparam int PART_W    = $clog2(MAX_ITEMS);
    localparam int TOTAL_RAW = $clog2(MAX_ITEMS * (MAX_ITEMS - 1) / 2 + 1);
    localparam int TOTAL_W   = (TOTAL_RAW > COUNT_W) ? TOTAL_RAW : COUNT_W;

    typedef struct packed {
        logic                      valid;
        logic                      active;   // value takes part in comparisons
        logic                      last;
        logic                      ovf;
        logic signed [VALUE_W-1:0] value;
        logic [PART_W-1:0]         partial;  // stored values greater than this one
    } token_t;

endpackage
`default_nettype wire

[src/ic_cell.sv]
// One chain cell: holds one stored value and adds one to the partial count of each smaller token.
`default_nettype none
module ic_cell (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           advance,
    input  wire ic_pkg::token_t tok_i,
    output ic_pkg::token_t      tok_o
);

    logic                              occ_reg, occ_next;
    logic signed [ic_pkg::VALUE_W-1:0] stored_reg, stored_next;
    ic_pkg::token_t                    tok_reg, tok_next;
    logic                              hit;

    assign hit = tok_i.valid && tok_i.active && occ_reg && (stored_reg > tok_i.value);

    always_comb begin
        occ_next    = occ_reg;
        stored_next = stored_reg;
        tok_next    = tok_i;
        tok_next.partial = tok_i.partial + ic_pkg::PART_W'(hit);
        if (tok_i.valid) begin
            if (tok_i.last) begin
                occ_next = 1'b0;
            end else if (!occ_reg && tok_i.active) begin
                occ_next        = 1'b1;
                stored_next     = tok_i.value;
                // kept here; the empty cells further on must not take it too
                tok_next.active = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg       <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else if (advance) begin
            occ_reg <= occ_next;
            tok_reg <= tok_next;
        end
        if (advance) begin
            stored_reg <= stored_next;
        end
    end

    assign tok_o = tok_reg;

endmodule
`default_nettype wire

[src/ic_front.sv]
// Input side: counts stored words, drops extras, builds tokens for the chain.
`default_nettype none
module ic_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              accept,
    input  wire logic signed [ic_pkg::VALUE_W-1:0] value,
    input  wire logic                              last_item,
    output ic_pkg::token_t                         tok_o
);

    logic [ic_pkg::IDX_W-1:0] count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic                     room;

    assign room = count_reg < ic_pkg::IDX_W'(ic_pkg::MAX_ITEMS);

    always_comb begin
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        tok_o.valid   = accept && (room || last_item);
        tok_o.active  = room;
        tok_o.last    = last_item;
        tok_o.ovf     = ovf_reg || !room;
        tok_o.value   = value;
        tok_o.partial = '0;
        if (accept) begin
            if (last_item) begin
                count_next = '0;
                ovf_next   = 1'b0;
            end else if (room) begin
                count_next = count_reg + 1'b1;
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule
`default_nettype wire

[src/ic_tail.sv]
// Chain exit: sums partial counts and holds the result word for the receiver.
`default_nettype none
module ic_tail (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire ic_pkg::token_t            tok_i,
    output logic                           advance,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [ic_pkg::COUNT_W-1:0]     m_inversion_count,
    output logic                           m_count_is_odd,
    output logic                           m_overflowed
);

    logic [ic_pkg::TOTAL_W-1:0] total_reg, total_next, sum;
    logic                       valid_reg, valid_next;
    logic [ic_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                       odd_reg, odd_next;
    logic                       ovf_reg, ovf_next;
    logic                       take;

    assign advance = !valid_reg || m_ready;
    assign take    = advance && tok_i.valid;
    assign sum     = total_reg + ic_pkg::TOTAL_W'(tok_i.partial);

    always_comb begin
        total_next = total_reg;
        valid_next = valid_reg && !m_ready;
        count_next = count_reg;
        odd_next   = odd_reg;
        ovf_next   = ovf_reg;
        if (take) begin
            total_next = sum;
            if (tok_i.last) begin
                total_next = '0;
                valid_next = 1'b1;
                odd_next   = sum[0];
                ovf_next   = tok_i.ovf;
                if (sum > ic_pkg::TOTAL_W'(ic_pkg::COUNT_MAX)) begin
                    count_next = ic_pkg::COUNT_W'(ic_pkg::COUNT_MAX);
                end else begin
                    count_next = sum[ic_pkg::COUNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            total_reg <= total_next;
            valid_reg <= valid_next;
        end
        count_reg <= count_next;
        odd_reg   <= odd_next;
        ovf_reg   <= ovf_next;
    end

    assign m_valid           = valid_reg;
    assign m_inversion_count = count_reg;
    assign m_count_is_odd    = odd_reg;
    assign m_overflowed      = ovf_reg;

`ifndef NO_ASSERTIONS
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_ready) |=> valid_reg)
        else $error("result word lost while stalled");
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && tok_i.last) |=> valid_reg)
        else $error("closing token gave no result");
    a_total_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && tok_i.last) |=> (total_reg == '0))
        else $error("running total not cleared after sequence");
    a_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && count_reg != ic_pkg::COUNT_W'(ic_pkg::COUNT_MAX))
        |-> (odd_reg == count_reg[0]))
        else $error("parity disagrees with count");
`endif

endmodule
`default_nettype wire

[src/inversion_counter.sv]
// Top level: streaming inversion counter built from a chain of compare cells.
//
// Input channel s_: one signed 32-bit word per accepted item, s_last_item
// closing the sequence. Result channel m_: one word per sequence holding
// the inversion count (saturated to 15 bits), its exact parity and a flag
// set when more than MAX_ITEMS words arrived; extra words are dropped.
// Throughput: one input word per cycle, across sequences too, unless a result stalls.
// Each word runs through MAX_ITEMS cells, one per cycle, collecting the
// number of earlier stored words greater than itself; the first cell it
// finds empty keeps it. The closing word empties the cells behind it.
// m_valid is set in the tail once the closing word has passed every cell.
// Reset (aresetn low, synchronous) empties every cell and drops any result.
// When the receiver stalls with a result pending, the whole chain and the
// input channel hold until the result is taken.
`default_nettype none
module inversion_counter (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [ic_pkg::VALUE_W-1:0] s_value,
    input  wire logic                              s_last_item,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [ic_pkg::COUNT_W-1:0]             m_inversion_count,
    output logic                                   m_count_is_odd,
    output logic                                   m_overflowed
);

    ic_pkg::token_t chain [ic_pkg::MAX_ITEMS+1];
    logic           advance;

    assign s_ready = advance;

    ic_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_valid && advance),
        .value     (s_value),
        .last_item (s_last_item),
        .tok_o     (chain[0])
    );

    for (genvar i = 0; i < ic_pkg::MAX_ITEMS; i++) begin : g_cell
        ic_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .tok_i   (chain[i]),
            .tok_o   (chain[i+1])
        );
    end

    ic_tail u_tail (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .tok_i             (chain[ic_pkg::MAX_ITEMS]),
        .advance           (advance),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_inversion_count (m_inversion_count),
        .m_count_is_odd    (m_count_is_odd),
        .m_overflowed      (m_overflowed)
    );

endmodule
`default_nettype wire

[tb/inversion_counter_tb.sv]
// Self-checking testbench for the streaming inversion counter.
module inversion_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT     = 36;
    localparam int HOLD_CYCLES  = 700;
    localparam int RANDOM_WORDS = 220;
    localparam int SETTLE       = ic_pkg::MAX_ITEMS + 20;

    typedef struct {
        logic [ic_pkg::COUNT_W-1:0] count;
        logic                       odd;
        logic                       ovf;
    } tally_t;

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic signed [ic_pkg::VALUE_W-1:0] s_value;
    logic                              s_last_item;
    logic                              m_valid;
    logic                              m_ready;
    logic [ic_pkg::COUNT_W-1:0]        m_inversion_count;
    logic                              m_count_is_odd;
    logic                              m_overflowed;

    // predictor state for the open sequence
    logic signed [ic_pkg::VALUE_W-1:0] seq_values [ic_pkg::MAX_ITEMS];
    int unsigned                       seq_len;
    longint unsigned                   seq_total;
    bit                                seq_dropped;

    tally_t      expected_tallies [$];
    int unsigned words_sent;
    int unsigned sequences_closed;
    int unsigned tallies_checked;
    int unsigned mismatches;
    int unsigned hold_cycles;
    bit          no_idle;

    inversion_counter u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_value           (s_value),
        .s_last_item       (s_last_item),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_inversion_count (m_inversion_count),
        .m_count_is_odd    (m_count_is_odd),
        .m_overflowed      (m_overflowed)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void count_word(input logic signed [ic_pkg::VALUE_W-1:0] v,
                                       input logic last);
        tally_t t;
        if (seq_len < ic_pkg::MAX_ITEMS) begin
            for (int i = 0; i < seq_len; i++) begin
                if (seq_values[i] > v) seq_total++;
            end
            seq_values[seq_len] = v;
            seq_len++;
        end else begin
            seq_dropped = 1'b1;
        end
        if (last) begin
            t.count = (seq_total > ic_pkg::COUNT_MAX) ?
                      ic_pkg::COUNT_W'(ic_pkg::COUNT_MAX) : ic_pkg::COUNT_W'(seq_total);
            t.odd   = seq_total[0];
            t.ovf   = seq_dropped;
            expected_tallies.push_back(t);
            sequences_closed++;
            seq_len     = 0;
            seq_total   = 0;
            seq_dropped = 1'b0;
        end
    endfunction

    // Leaves s_valid high after acceptance; the next call or the caller lowers it.
    task automatic send_word(input logic signed [ic_pkg::VALUE_W-1:0] v, input logic last);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_value     <= v;
        s_last_item <= last;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        count_word(v, last);
        words_sent++;
    endtask

    function automatic logic signed [ic_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(2))
            0: begin
                return $urandom;
            end
            1: begin
                return int'($urandom_range(8)) - 4;
            end
            default: begin
                if ($urandom_range(1) == 0) return 32'h7FFF_FFFF - $urandom_range(3);
                return 32'h8000_0000 + $urandom_range(3);
            end
        endcase
    endfunction

    task automatic test_single_values();
        send_word(32'sh7FFF_FFFF, 1'b1);
        send_word(32'sh8000_0000, 1'b1);
        send_word(32'sd0, 1'b1);
        send_word(-32'sd1, 1'b1);
    endtask

    task automatic test_pairs_and_ties();
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh8000_0000, 1'b1);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh7FFF_FFFF, 1'b1);
        send_word(32'sd5, 1'b0);
        send_word(32'sd5, 1'b1);
        send_word(-32'sd1, 1'b0);
        send_word(32'sd0, 1'b1);
        send_word(32'sd0, 1'b0);
        send_word(-32'sd1, 1'b1);
    endtask

    task automatic test_short_descending();
        for (int i = 0; i < 6; i++) send_word(3 - i, i == 5);
        send_word(32'sd7, 1'b0);
        send_word(32'sd7, 1'b0);
        send_word(32'sd2, 1'b1);
    endtask

    // full store, strictly descending: the largest count a sequence can reach, below saturation
    task automatic test_full_descending();
        no_idle = 1'b1;
        for (int i = 0; i < ic_pkg::MAX_ITEMS; i++) begin
            send_word(32'sh7FFF_FFFF - i * 32'sh0080_0001, i == ic_pkg::MAX_ITEMS - 1);
        end
        no_idle = 1'b0;
    endtask

    // words past the store limit are dropped; the dropped closing word still ends it
    task automatic test_overflow();
        for (int i = 0; i < ic_pkg::MAX_ITEMS + 2; i++) begin
            send_word(pick_value(), i == ic_pkg::MAX_ITEMS + 1);
        end
        send_word(32'sd9, 1'b0);
        send_word(32'sd1, 1'b1);
    endtask

    task automatic test_result_stall();
        hold_cycles = HOLD_CYCLES;
        for (int s = 0; s < 60; s++) begin
            for (int i = 0; i < 4; i++) send_word(pick_value(), i == 3);
        end
    endtask

    task automatic test_random_sequences();
        int unsigned start;
        int unsigned len;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            if ($urandom_range(39) == 0) len = $urandom_range(ic_pkg::MAX_ITEMS + 4, 60);
            else len = $urandom_range(24, 1);
            for (int i = 0; i < len; i++) send_word(pick_value(), i == len - 1);
        end
    endtask

    // result channel: ready pattern, with the long hold counted down here
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // result checker: sample mid-cycle, the word is taken at the next rising edge
    initial begin
        tally_t t;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (m_valid && m_ready) begin
                if (expected_tallies.size() == 0) begin
                    $error("unexpected result word: count %0d odd %0d ovf %0d",
                           m_inversion_count, m_count_is_odd, m_overflowed);
                    mismatches++;
                end else begin
                    t = expected_tallies.pop_front();
                    tallies_checked++;
                    if (m_inversion_count !== t.count) begin
                        $error("inversion_count: expected %0d, actual %0d",
                               t.count, m_inversion_count);
                        mismatches++;
                    end
                    if (m_count_is_odd !== t.odd) begin
                        $error("count_is_odd: expected %0d, actual %0d", t.odd, m_count_is_odd);
                        mismatches++;
                    end
                    if (m_overflowed !== t.ovf) begin
                        $error("overflowed: expected %0d, actual %0d", t.ovf, m_overflowed);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_value     = '0;
        s_last_item = 1'b0;
        seq_len     = 0;
        seq_total   = 0;
        seq_dropped = 1'b0;
        hold_cycles = 0;
        no_idle     = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_single_values();
        test_pairs_and_ties();
        test_short_descending();
        test_full_descending();
        test_overflow();
        test_result_stall();
        test_random_sequences();

        s_valid <= 1'b0;
        while (expected_tallies.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("Sent %0d words in %0d sequences; %0d results checked, %0d mismatches.",
                 words_sent, sequences_closed, tallies_checked, mismatches);
        $display("Included a full store, dropped words and a %0d-cycle result stall.",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
